>>> hw/rtl/scfp_pkg.sv
// shared types and constants of the serial command frame parser
package scfp_pkg;

  localparam int unsigned PAYLOAD_LEN = 10;
  localparam int unsigned IDX_W       = 4;
  localparam int unsigned CFG_IDX_W   = 8;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_HEADER  = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_COMMAND = 8'd1;

  // payload byte positions
  localparam logic [IDX_W-1:0] IDX_FIRST   = 4'd0;
  localparam logic [IDX_W-1:0] IDX_CRC_END = 4'd8;
  localparam logic [IDX_W-1:0] IDX_CRC_LO  = 4'd8;
  localparam logic [IDX_W-1:0] IDX_LAST    = IDX_W'(PAYLOAD_LEN - 1);

  // sync bytes from the configuration registers
  typedef struct packed {
    logic [7:0] header;
    logic [7:0] command;
  } sync_cfg_t;

  // one classified payload byte, front to back
  typedef struct packed {
    logic [IDX_W-1:0] idx;
    logic [7:0]       data;
  } item_t;

  // one completed frame
  typedef struct packed {
    logic [31:0] linear;
    logic [31:0] angular;
    logic        crc_ok;
  } result_t;

endpackage

>>> hw/rtl/scfp_fifo.sv
// small generic queue with push/full and pop/empty sides
module scfp_fifo import scfp_pkg::*; #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [Width-1:0] data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [Width-1:0] data_o,
  output logic             empty_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] PtrLast = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] CntFull = CntW'(Depth);

  logic [Width-1:0] mem_q [Depth];
  logic [PtrW-1:0]  wr_q, wr_d, rd_q, rd_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == CntFull);
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rd_q];

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (do_push) begin
      wr_d = (wr_q == PtrLast) ? '0 : wr_q + 1'b1;
    end
    if (do_pop) begin
      rd_d = (rd_q == PtrLast) ? '0 : rd_q + 1'b1;
    end
    unique case ({do_push, do_pop})
      2'b10:   cnt_d = cnt_q + 1'b1;
      2'b01:   cnt_d = cnt_q - 1'b1;
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= data_i;
    end
  end

endmodule

>>> hw/rtl/scfp_front.sv
// front end: header/command hunt and payload byte classification
module scfp_front import scfp_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  sync_cfg_t cfg_i,
  input  logic      accept_i,
  input  logic [7:0] rx_byte_i,
  output logic      item_push_o,
  output item_t     item_o
);

  typedef enum logic [1:0] {PH_HUNT, PH_CMD, PH_DATA} phase_e;

  phase_e           phase_q;
  logic [IDX_W-1:0] idx_q;

  assign item_push_o = accept_i && (phase_q == PH_DATA);
  assign item_o      = '{idx: idx_q, data: rx_byte_i};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_HUNT;
      idx_q   <= '0;
    end else if (accept_i) begin
      unique case (phase_q)
        PH_HUNT: begin
          if (rx_byte_i == cfg_i.header) phase_q <= PH_CMD;
        end
        PH_CMD: begin
          // a wrong command byte is not retried as a header
          phase_q <= (rx_byte_i == cfg_i.command) ? PH_DATA : PH_HUNT;
          idx_q   <= '0;
        end
        PH_DATA: begin
          if (idx_q == IDX_LAST) begin
            phase_q <= PH_HUNT;
            idx_q   <= '0;
          end else begin
            idx_q <= idx_q + 1'b1;
          end
        end
        default: begin
          phase_q <= PH_HUNT;
          idx_q   <= '0;
        end
      endcase
    end
  end

  a_idx_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    idx_q <= IDX_LAST)
    else $error("payload index out of range");

  a_idx_only_in_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (idx_q != IDX_FIRST) |-> (phase_q == PH_DATA))
    else $error("nonzero index outside payload phase");

  a_last_returns_hunt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (item_push_o && (idx_q == IDX_LAST)) |=> (phase_q == PH_HUNT))
    else $error("frame end did not return to hunting");

endmodule

>>> hw/rtl/scfp_back.sv
// back end: payload assembly, crc-16 and result build
module scfp_back import scfp_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    item_empty_i,
  input  item_t   item_i,
  output logic    item_pop_o,
  input  logic    res_full_i,
  output logic    res_push_o,
  output result_t res_o
);

  localparam logic [15:0] CrcInit = 16'hFFFF;
  localparam logic [15:0] CrcPoly = 16'hA001;

  function automatic logic [15:0] crc_update(logic [15:0] crc, logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CrcPoly) : (c >> 1);
    end
    return c;
  endfunction

  logic [63:0] speed_q, speed_d;
  logic [7:0]  crc_lo_q, crc_lo_d;
  logic [15:0] crc_q, crc_d, crc_base;

  // take a byte only while the result queue has room
  assign item_pop_o = !item_empty_i && !res_full_i;
  assign res_push_o = item_pop_o && (item_i.idx == IDX_LAST);
  assign crc_base   = (item_i.idx == IDX_FIRST) ? CrcInit : crc_q;

  always_comb begin
    speed_d  = speed_q;
    crc_lo_d = crc_lo_q;
    crc_d    = crc_q;
    if (item_pop_o) begin
      if (item_i.idx < IDX_CRC_END) begin
        speed_d = {speed_q[55:0], item_i.data};
        crc_d   = crc_update(crc_base, item_i.data);
      end
      if (item_i.idx == IDX_CRC_LO) crc_lo_d = item_i.data;
    end
  end

  assign res_o = '{linear:  speed_q[63:32],
                   angular: speed_q[31:0],
                   crc_ok:  ({item_i.data, crc_lo_q} == crc_q)};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      crc_q <= CrcInit;
    end else begin
      crc_q <= crc_d;
    end
  end

  always_ff @(posedge clk_i) begin
    speed_q  <= speed_d;
    crc_lo_q <= crc_lo_d;
  end

  a_no_pop_when_blocked: assert property (@(posedge clk_i) disable iff (!rst_ni)
    item_pop_o |-> (!res_full_i && !item_empty_i))
    else $error("byte taken while result queue full");

  a_idx_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    item_pop_o |-> (item_i.idx <= IDX_LAST))
    else $error("queued byte carries bad index");

  a_crc_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !item_pop_o |=> $stable(crc_q))
    else $error("crc changed without a byte");

endmodule

>>> hw/rtl/serial_command_frame_parser.sv
// top level of the serial command frame parser
//
// Serial bytes come in one request per cycle through push_i/full_o while
// full_o is low. The front end hunts for the header byte, checks the command
// byte that must follow and tags each of the next ten payload bytes with its
// position; tagged bytes go into a short queue. The back end drains that
// queue one byte per cycle while the result queue has room, shifts bytes 0..7
// into the two big-endian speed words, runs the Modbus CRC-16 (init 0xFFFF,
// reflected poly 0xA001) over them in one byte-wide step and, on byte 9,
// compares the result with bytes 8 (low) and 9 (high). One result per frame
// lands in the result queue and is read with pop_i/empty_o. A frame is twelve
// bytes; its result shows once its last byte has passed both queues. full_o
// rises only when the byte queue fills, i.e. when results are not popped.
// Configuration writes are always ready and take effect from the next byte.
module serial_command_frame_parser import scfp_pkg::*; #(
  parameter int unsigned ITEM_DEPTH   = 2,
  parameter int unsigned RESULT_DEPTH = 2
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // byte input
  input  logic                 push_i,
  input  logic [7:0]           rx_byte_i,
  output logic                 full_o,
  // results
  input  logic                 pop_i,
  output logic                 empty_o,
  output logic [31:0]          linear_bits_o,
  output logic [31:0]          angular_bits_o,
  output logic                 crc_ok_o,
  // configuration writes
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [7:0]           cfg_data_i
);

  sync_cfg_t cfg_q;
  logic      in_accept;
  logic      item_push, item_full, item_pop, item_empty;
  item_t     item_wr, item_rd;
  logic      res_push, res_full;
  result_t   res_wr, res_rd;

  // register file: both sync bytes, indexes beyond the list are dropped
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        CFG_HEADER:  cfg_q.header  <= cfg_data_i;
        CFG_COMMAND: cfg_q.command <= cfg_data_i;
        default:     cfg_q         <= cfg_q;
      endcase
    end
  end

  // a byte is taken whenever the byte queue has room
  assign full_o    = item_full;
  assign in_accept = push_i && !full_o;

  scfp_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .accept_i    (in_accept),
    .rx_byte_i   (rx_byte_i),
    .item_push_o (item_push),
    .item_o      (item_wr)
  );

  // decouples classification from assembly
  scfp_fifo #(
    .Width ($bits(item_t)),
    .Depth (ITEM_DEPTH)
  ) u_item_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (item_push),
    .data_i  (item_wr),
    .full_o  (item_full),
    .pop_i   (item_pop),
    .data_o  (item_rd),
    .empty_o (item_empty)
  );

  scfp_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_empty_i (item_empty),
    .item_i       (item_rd),
    .item_pop_o   (item_pop),
    .res_full_i   (res_full),
    .res_push_o   (res_push),
    .res_o        (res_wr)
  );

  // finished frames wait here for the consumer
  scfp_fifo #(
    .Width ($bits(result_t)),
    .Depth (RESULT_DEPTH)
  ) u_res_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_push),
    .data_i  (res_wr),
    .full_o  (res_full),
    .pop_i   (pop_i),
    .data_o  (res_rd),
    .empty_o (empty_o)
  );

  assign linear_bits_o  = res_rd.linear;
  assign angular_bits_o = res_rd.angular;
  assign crc_ok_o       = res_rd.crc_ok;

  a_full_means_no_take: assert property (@(posedge clk_i) disable iff (!rst_ni)
    full_o |-> !item_push)
    else $error("byte queued while byte queue full");

  a_res_only_from_back: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_push |-> (item_pop && !res_full))
    else $error("result pushed without a closing byte");

  a_back_drains: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!item_empty && !res_full) |-> item_pop)
    else $error("back end idles with work and room");

endmodule
